>>> hdl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, disabled in reset
`define AST_IMP(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) else $error(msg);
// next-cycle implication, disabled in reset
`define AST_NXT(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error(msg);
// condition that must hold in the cycle after reset is seen
`define AST_RST(lbl, ck, rs, c, msg) \
  lbl: assert property (@(posedge ck) (rs) |=> (c)) else $error(msg);
`endif

>>> hdl/bgs_pkg.sv
// types, constants and helper functions of the burgers step unit
package bgs_pkg;

  localparam int CELL_W = 16;
  localparam int FLUX_W = 31;
  localparam int TIME_W = 32;
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 40;

  // operation codes of an input transaction
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_CELL_COUNT = 2'd0;
  localparam logic [1:0] REG_COURANT    = 2'd1;
  localparam logic [1:0] REG_CELL_WIDTH = 2'd2;
  localparam logic [1:0] REG_END_TIME   = 2'd3;

  typedef enum logic [18:0] {
    S_IDLE   = 19'b0000000000000000001,
    S_RDW    = 19'b0000000000000000010,
    S_PK_A   = 19'b0000000000000000100,
    S_PK_B   = 19'b0000000000000001000,
    S_DT_MUL = 19'b0000000000000010000,
    S_DT_ST  = 19'b0000000000000100000,
    S_DT_DIV = 19'b0000000000001000000,
    S_DT_FIX = 19'b0000000000010000000,
    S_DT_ADV = 19'b0000000000100000000,
    S_FX_A   = 19'b0000000001000000000,
    S_FX_B   = 19'b0000000010000000000,
    S_FX_W   = 19'b0000000100000000000,
    S_UP_A   = 19'b0000001000000000000,
    S_UP_B   = 19'b0000010000000000000,
    S_UP_MUL = 19'b0000100000000000000,
    S_UP_ST  = 19'b0001000000000000000,
    S_UP_DIV = 19'b0010000000000000000,
    S_UP_WR  = 19'b0100000000000000000,
    S_DONE   = 19'b1000000000000000000
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  // squared godunov state at one interface, exact riemann solution
  function automatic logic [FLUX_W-1:0] star_sq(logic signed [CELL_W-1:0] ul,
                                                logic signed [CELL_W-1:0] ur);
    logic signed [CELL_W:0]   sum;
    logic signed [CELL_W-1:0] s;
    logic signed [2*CELL_W-1:0] sq;
    sum = (CELL_W+1)'(ul) + (CELL_W+1)'(ur);
    if (ul > ur) begin
      s = (sum >= 0) ? ul : ur;
    end else if (ul >= 0) begin
      s = ul;
    end else if (ur <= 0) begin
      s = ur;
    end else begin
      s = '0;
    end
    sq = s * s;
    return sq[FLUX_W-1:0];
  endfunction

endpackage

>>> hdl/burgers_godunov_step_unit.sv
// top level of the burgers godunov step unit
// write and clear go from idle to S_DONE, a read passes S_RDW first; results leave through a register
// a new transaction is taken only in idle, once the result of the last one has been offered
// step: a peak scan, dt, fluxes, then the update of each cell, with dt and every
//   update quotient from the shared one-bit-per-cycle divider
// synchronous reset clears control, elapsed time and config; cell ram is not cleared
module burgers_godunov_step_unit #(
  parameter int MAX_CELLS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [9:0]  cell_index,
  input  logic signed [15:0] write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] read_value,
  output logic [31:0] time_step,
  output logic [31:0] elapsed_out,
  output logic        zero_speed,
  output logic        end_reached,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bgs_pkg::*;

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam logic [16:0] MAXC = 17'(MAX_CELLS);

  // configuration
  logic [10:0] cell_count;
  logic [15:0] courant;
  logic [23:0] cell_width;
  logic [31:0] end_time;

  state_t state;
  logic [31:0] elapsed;
  logic [31:0] dt;
  logic [CW-1:0] cnt;
  logic [15:0] peak;
  logic signed [15:0] rd;
  logic signed [15:0] first;
  logic signed [15:0] prev;
  logic signed [15:0] u;
  logic [FLUX_W-1:0] fl;
  logic [FLUX_W-1:0] fr;
  logic [FLUX_W-1:0] mag;
  logic neg;
  logic [DVD_W-1:0] prod;
  logic [DVD_W-1:0] q;
  logic zero_flag;
  logic sat_flag;
  logic rd_in_range;

  // ram ports
  logic              cell_we;
  logic [AW-1:0]     cell_waddr;
  logic [15:0]       cell_wdata;
  logic [AW-1:0]     cell_raddr;
  logic [15:0]       cell_rdata;
  logic              flux_we;
  logic [AW-1:0]     flux_waddr;
  logic [FLUX_W-1:0] flux_wdata;
  logic [FLUX_W-1:0] flux_rdata;

  div_ctl_t         div_req;
  div_ctl_t         div_rsp;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;

  // derived values
  logic [16:0]   idx_ext;
  logic          idx_ok;
  logic [16:0]   n_full;
  logic [CW-1:0] n_act;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] n_m1;
  logic signed [16:0] abs_v;
  logic [15:0]   peak_new;
  logic [32:0]   el_sum;
  logic [31:0]   dt_fin;
  logic signed [65:0] upd_sum;
  logic          upd_hi;
  logic          upd_lo;
  logic signed [15:0] upd_val;
  logic          accept;
  logic          out_slot;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_slot  = !out_valid || out_ready;

  assign idx_ext = {7'd0, cell_index};
  assign idx_ok  = idx_ext < MAXC;

  // active cell count clamped to two and the store depth
  always_comb begin
    n_full = {6'd0, cell_count};
    if (n_full < 17'd2) begin
      n_full = 17'd2;
    end else if (n_full > MAXC) begin
      n_full = MAXC;
    end
  end
  assign n_act   = n_full[CW-1:0];
  assign cnt_inc = cnt + 1'b1;
  assign n_m1    = n_act - 1'b1;

  // magnitude for the peak scan
  assign abs_v    = cell_rdata[15] ? 17'sd0 - {cell_rdata[15], cell_rdata}
                                   : {1'b0, cell_rdata};
  assign peak_new = (abs_v[15:0] > peak) ? abs_v[15:0] : peak;

  // dt clamp against the end time
  assign el_sum = {1'b0, elapsed} + {1'b0, dt};
  always_comb begin
    if (elapsed >= end_time) begin
      dt_fin = '0;
    end else if (el_sum > {1'b0, end_time}) begin
      dt_fin = end_time - elapsed;
    end else begin
      dt_fin = dt;
    end
  end

  // conservative update with saturation
  assign upd_sum = neg ? ({{50{u[15]}}, u} - $signed({2'b00, q}))
                       : ({{50{u[15]}}, u} + $signed({2'b00, q}));
  assign upd_hi  = upd_sum > 66'sd32767;
  assign upd_lo  = upd_sum < -66'sd32768;
  assign upd_val = upd_hi ? 16'sh7fff : (upd_lo ? 16'sh8000 : upd_sum[15:0]);

  // ram access selection
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = idx_ext[AW-1:0];
    cell_wdata = write_value;
    cell_raddr = cnt[AW-1:0];
    flux_we    = 1'b0;
    flux_waddr = n_m1[AW-1:0];
    flux_wdata = star_sq(prev, first);
    case (state)
      S_IDLE: begin
        cell_raddr = idx_ext[AW-1:0];
        cell_we    = accept && (op == OP_WRITE) && idx_ok;
      end
      S_FX_B: begin
        flux_we    = (cnt != '0);
        flux_waddr = AW'(cnt - 1'b1);
        flux_wdata = star_sq(prev, cell_rdata);
      end
      S_FX_W: begin
        flux_we = 1'b1;
      end
      S_UP_WR: begin
        cell_we    = 1'b1;
        cell_waddr = cnt[AW-1:0];
        cell_wdata = upd_val;
      end
      default: begin
      end
    endcase
  end

  // divider operand selection
  always_comb begin
    div_req       = '0;
    div_req.start = (state == S_DT_ST) || (state == S_UP_ST);
    if (state == S_DT_ST) begin
      div_divisor  = {20'd0, peak, 4'd0};
      div_dividend = prod;
    end else begin
      div_divisor  = {3'd0, cell_width, 13'd0};
      div_dividend = prod + {28'd0, cell_width, 12'd0};
    end
  end

  bgs_ram #(.WIDTH(16), .DEPTH(MAX_CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  bgs_ram #(.WIDTH(FLUX_W), .DEPTH(MAX_CELLS)) u_flux_ram (
    .clk   (clk),
    .we    (flux_we),
    .waddr (flux_waddr),
    .wdata (flux_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (flux_rdata)
  );

  bgs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (div_req),
    .ctl_out  (div_rsp),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= 11'd1024;
      courant    <= 16'd52429;
      cell_width <= 24'd16384;
      end_time   <= 32'd16777216;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELL_COUNT: cell_count <= cfg_data[10:0];
        REG_COURANT:    courant    <= cfg_data[15:0];
        REG_CELL_WIDTH: cell_width <= cfg_data[23:0];
        REG_END_TIME:   end_time   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      elapsed   <= '0;
      out_valid <= 1'b0;
    end else begin
      // result handshake
      if (state == S_DONE && out_slot) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_WRITE: state <= S_DONE;
              OP_READ:  state <= S_RDW;
              OP_CLEAR: begin
                elapsed <= '0;
                state   <= S_DONE;
              end
              default: state <= S_PK_A;
            endcase
          end
        end
        S_RDW:    state <= S_DONE;
        S_PK_A:   state <= S_PK_B;
        S_PK_B: begin
          if (cnt_inc == n_act) begin
            state <= (peak_new == '0) ? S_DONE : S_DT_MUL;
          end else begin
            state <= S_PK_A;
          end
        end
        S_DT_MUL: state <= S_DT_ST;
        S_DT_ST:  state <= S_DT_DIV;
        S_DT_DIV: begin
          if (div_rsp.done) begin
            state <= S_DT_FIX;
          end
        end
        S_DT_FIX: state <= S_DT_ADV;
        S_DT_ADV: begin
          elapsed <= elapsed + dt;
          state   <= (dt == '0) ? S_DONE : S_FX_A;
        end
        S_FX_A:   state <= S_FX_B;
        S_FX_B:   state <= (cnt_inc == n_act) ? S_FX_W : S_FX_A;
        S_FX_W:   state <= S_UP_A;
        S_UP_A:   state <= S_UP_B;
        S_UP_B:   state <= S_UP_MUL;
        S_UP_MUL: state <= S_UP_ST;
        S_UP_ST:  state <= S_UP_DIV;
        S_UP_DIV: begin
          if (div_rsp.done) begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR:  state <= (cnt_inc == n_act) ? S_DONE : S_UP_A;
        S_DONE: begin
          if (out_slot) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cnt         <= '0;
        peak        <= '0;
        dt          <= '0;
        rd          <= '0;
        zero_flag   <= 1'b0;
        sat_flag    <= 1'b0;
        rd_in_range <= idx_ok;
      end
      S_RDW: begin
        rd <= rd_in_range ? cell_rdata : 16'sd0;
      end
      S_PK_B: begin
        peak      <= peak_new;
        cnt       <= cnt_inc;
        zero_flag <= (cnt_inc == n_act) && (peak_new == '0);
      end
      S_DT_MUL: begin
        prod <= DVD_W'({24'd0, courant} * {16'd0, cell_width});
      end
      S_DT_DIV: begin
        if (div_rsp.done) begin
          dt <= (q[DVD_W-1:32] != '0) ? 32'hffff_ffff : q[31:0];
        end
      end
      S_DT_FIX: begin
        dt <= dt_fin;
      end
      S_DT_ADV: begin
        cnt <= '0;
      end
      S_FX_B: begin
        if (cnt == '0) begin
          first <= cell_rdata;
        end
        prev <= cell_rdata;
        cnt  <= cnt_inc;
      end
      S_FX_W: begin
        fl  <= flux_wdata;
        cnt <= '0;
      end
      S_UP_B: begin
        fr  <= flux_rdata;
        u   <= cell_rdata;
        neg <= fl < flux_rdata;
        mag <= (fl >= flux_rdata) ? fl - flux_rdata : flux_rdata - fl;
      end
      S_UP_MUL: begin
        prod <= DVD_W'({31'd0, dt} * {32'd0, mag});
      end
      S_UP_WR: begin
        sat_flag <= sat_flag || upd_hi || upd_lo;
        fl       <= fr;
        cnt      <= cnt_inc;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_slot) begin
      read_value  <= rd;
      time_step   <= dt;
      elapsed_out <= elapsed;
      zero_speed  <= zero_flag;
      end_reached <= (elapsed == end_time);
      saturated   <= sat_flag;
    end
  end
endmodule

>>> hdl/bgs_ram.sv
// generic simple dual port ram with registered read
module bgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/bgs_div.sv
// restoring serial divider, one quotient bit per cycle
module bgs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  bgs_pkg::div_ctl_t            ctl_in,
  output bgs_pkg::div_ctl_t            ctl_out,
  input  logic [bgs_pkg::DVD_W-1:0]    dividend,
  input  logic [bgs_pkg::DVS_W-1:0]    divisor,
  output logic [bgs_pkg::DVD_W-1:0]    quotient
);
  import bgs_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [6:0]       steps;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   shifted;
  logic             fits;

  // trial subtract of the shifted partial remainder
  assign shifted = {rem, quotient[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy  <= 1'b1;
        steps <= 7'(DVD_W);
      end else if (busy) begin
        steps <= steps - 7'd1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient shares the dividend register
  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DVD_W-2:0], fits};
      rem      <= fits ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
    end
  end

  always_comb begin
    ctl_out       = '0;
    ctl_out.start = busy;
    ctl_out.done  = done;
  end
endmodule

>>> hdl/bgs_checker.sv
// port-level checks of the burgers step unit and their bind
`include "assert_macros.svh"
module bgs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [15:0] read_value,
  input logic [31:0] time_step,
  input logic        zero_speed,
  input logic        saturated
);
  // a pending result stays offered
  `AST_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  // a zero peak step reports no dt and no clipping
  `AST_IMP(a_zero_step, clk, rst, out_valid && zero_speed, time_step == 32'd0 && !saturated, "zero step")
  // read data only comes with read transactions
  `AST_IMP(a_read_only, clk, rst, out_valid && read_value != 16'sd0, time_step == 32'd0 && !zero_speed && !saturated, "read mixed")
  // nothing is offered right after reset
  `AST_RST(a_rst_quiet, clk, rst, !out_valid, "valid after reset")
endmodule

bind burgers_godunov_step_unit bgs_checker u_bgs_checker (.*);

>>> tb/testbench.sv
// self-checking testbench for the burgers godunov step unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bgs_pkg::*;

  localparam int NCELLS = 1024;

  typedef struct {
    logic [1:0]         op;
    logic [9:0]         idx;
    logic signed [15:0] wval;
  } cell_op_t;

  typedef struct {
    logic signed [15:0] rd;
    logic [31:0]        dt;
    logic [31:0]        elapsed;
    logic               zs;
    logic               er;
    logic               sat;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = OP_WRITE;
  logic [9:0] cell_index = '0;
  logic signed [15:0] write_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] read_value;
  logic [31:0] time_step;
  logic [31:0] elapsed_out;
  logic zero_speed;
  logic end_reached;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_CELL_COUNT;
  logic [31:0] cfg_data = '0;

  // shadow of the grid, the clock and the registers
  logic signed [15:0] grid [NCELLS];
  logic [31:0] sim_time;
  logic [10:0] n_cells;
  logic [15:0] cfl;
  logic [23:0] dx;
  logic [31:0] t_end;
  logic [31:0] flux [NCELLS];

  cell_op_t     pending_ops [$];
  step_result_t expected_results [$];
  int errors = 0;
  bit op_taken = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;

  burgers_godunov_step_unit dut (.*);

  always #5 clk = ~clk;

  // exact riemann star state
  function automatic int riemann_star(int ul, int ur);
    if (ul > ur) return (ul + ur >= 0) ? ul : ur;
    if (ul >= 0) return ul;
    if (ur <= 0) return ur;
    return 0;
  endfunction

  // one godunov step on the shadow grid
  function automatic void advance_grid(output logic [31:0] dt_o, output logic zs_o,
                                       output logic sat_o);
    int n, a, s, peak;
    longint unsigned dt, den, mag, q;
    longint v;
    int unsigned fl, fr;
    n = (n_cells < 2) ? 2 : (n_cells > NCELLS) ? NCELLS : n_cells;
    peak = 0;
    sat_o = 0;
    for (int i = 0; i < n; i++) begin
      a = grid[i];
      if (a < 0) a = -a;
      if (a > peak) peak = a;
    end
    if (peak == 0) begin
      dt_o = '0;
      zs_o = 1;
      return;
    end
    zs_o = 0;
    dt = (longint'(cfl) * longint'(dx)) / (longint'(peak) * 16);
    if (dt > 64'hFFFFFFFF) dt = 64'hFFFFFFFF;
    if (sim_time >= t_end) dt = 0;
    else if (longint'(sim_time) + dt > longint'(t_end)) dt = t_end - sim_time;
    sim_time = sim_time + dt[31:0];
    for (int i = 0; i < n; i++) begin
      s = riemann_star(grid[i], grid[(i + 1 == n) ? 0 : i + 1]);
      flux[i] = s * s;
    end
    den = longint'(dx == 0 ? 24'd1 : dx) << 13;
    for (int i = 0; i < n; i++) begin
      fl = flux[i == 0 ? n - 1 : i - 1];
      fr = flux[i];
      mag = (fl >= fr) ? fl - fr : fr - fl;
      q = (dt * mag + den / 2) / den;
      v = grid[i];
      v = (fl >= fr) ? v + longint'(q) : v - longint'(q);
      if (v > 32767) begin
        v = 32767;
        sat_o = 1;
      end else if (v < -32768) begin
        v = -32768;
        sat_o = 1;
      end
      grid[i] = v[15:0];
    end
    dt_o = dt[31:0];
  endfunction

  // expected result of one input transaction
  function automatic step_result_t model_op(cell_op_t c);
    step_result_t r;
    r = '{rd: '0, dt: '0, elapsed: '0, zs: 0, er: 0, sat: 0};
    case (c.op)
      OP_WRITE: grid[c.idx] = c.wval;
      OP_STEP:  advance_grid(r.dt, r.zs, r.sat);
      OP_READ:  r.rd = grid[c.idx];
      OP_CLEAR: sim_time = '0;
      default: begin
      end
    endcase
    r.elapsed = sim_time;
    r.er = (sim_time == t_end);
    return r;
  endfunction

  // input driver, changes on the falling edge
  always @(negedge clk) begin
    cell_op_t c;
    if (!(in_valid && !op_taken)) begin
      op_taken = 0;
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0 && !rst) begin
        if (!quiet && $urandom_range(5) == 0) begin
          gap_cnt = $urandom_range(8);
          in_valid <= 1'b0;
        end else begin
          c = pending_ops.pop_front();
          op <= c.op;
          cell_index <= c.idx;
          write_value <= c.wval;
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(7) == 0) begin
      stall_cnt = $urandom_range(8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    step_result_t e;
    cell_op_t c;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CELL_COUNT: n_cells = cfg_data[10:0];
          REG_COURANT:    cfl = cfg_data[15:0];
          REG_CELL_WIDTH: dx = cfg_data[23:0];
          REG_END_TIME:   t_end = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        op_taken = 1;
        c = '{op: op, idx: cell_index, wval: write_value};
        expected_results.push_back(model_op(c));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, read_value %0d elapsed %h", $realtime,
                   read_value, elapsed_out);
        end else begin
          e = expected_results.pop_front();
          if (read_value !== e.rd || time_step !== e.dt || elapsed_out !== e.elapsed ||
              zero_speed !== e.zs || end_reached !== e.er || saturated !== e.sat) begin
            errors++;
            $display("%0t: mismatch expected rd %0d dt %h el %h zs %b er %b sat %b",
                     $realtime, e.rd, e.dt, e.elapsed, e.zs, e.er, e.sat);
            $display("%0t:          actual   rd %0d dt %h el %h zs %b er %b sat %b",
                     $realtime, read_value, time_step, elapsed_out, zero_speed,
                     end_reached, saturated);
          end
        end
      end
    end
  end

  task automatic add_op(logic [1:0] o, int i, int v);
    pending_ops.push_back('{op: o, idx: i[9:0], wval: v[15:0]});
  endtask

  // drains everything in flight
  task automatic wait_idle();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] i, logic [31:0] d);
    @(negedge clk);
    cfg_index <= i;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int nc, int c, int w, longint te);
    write_reg(REG_CELL_COUNT, 32'(nc));
    write_reg(REG_COURANT, 32'(c));
    write_reg(REG_CELL_WIDTH, 32'(w));
    write_reg(REG_END_TIME, te[31:0]);
  endtask

  // random burst of mostly well-formed work over a small grid
  task automatic random_ops(int count, int span);
    int p;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(99);
      if (p < 45)
        add_op(OP_WRITE, $urandom_range(span - 1),
               ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(8000)) - 4000);
      else if (p < 65) add_op(OP_STEP, 0, $urandom);
      else if (p < 90) add_op(OP_READ, $urandom_range(NCELLS - 1), $urandom);
      else if (p < 95) add_op(OP_WRITE, $urandom_range(NCELLS - 1), $urandom);
      else add_op(OP_CLEAR, $urandom, $urandom);
    end
  endtask

  initial begin
    int sp;
    n_cells = 1024;
    cfl = 52429;
    dx = 16384;
    t_end = 32'd16777216;
    sim_time = '0;
    for (int i = 0; i < NCELLS; i++) grid[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the whole store so no unwritten cell is ever touched
    add_op(OP_CLEAR, 0, 0);
    add_op(OP_WRITE, 0, 32767);
    add_op(OP_WRITE, 1, -32768);
    add_op(OP_WRITE, 1023, 0);
    for (int i = 2; i < 1023; i++) add_op(OP_WRITE, i, $signed($urandom_range(2000)) - 1000);
    add_op(OP_READ, 0, 0);
    add_op(OP_READ, 1, 0);
    add_op(OP_READ, 1023, 0);
    // full grid step with reset settings
    add_op(OP_STEP, 0, 0);
    add_op(OP_READ, 512, 0);
    wait_idle();

    // count above the store clamps, tiny cfl
    set_regs(2047, 1, 1, 0);
    add_op(OP_STEP, 0, 0);
    wait_idle();

    // count below two, largest cfl and dx: dt saturates, cells clip
    set_regs(0, 65535, 24'hFFFFFF, 64'hFFFFFFFF);
    add_op(OP_WRITE, 0, 1);
    add_op(OP_WRITE, 1, -1);
    add_op(OP_STEP, 0, 0);
    add_op(OP_WRITE, 0, 32767);
    add_op(OP_WRITE, 1, -32768);
    add_op(OP_STEP, 0, 0);
    add_op(OP_STEP, 0, 0);
    add_op(OP_READ, 0, 0);
    add_op(OP_READ, 1, 0);
    // all zero grid
    add_op(OP_WRITE, 0, 0);
    add_op(OP_WRITE, 1, 0);
    add_op(OP_STEP, 0, 0);
    add_op(OP_CLEAR, 0, 0);
    wait_idle();

    // zero cell width and zero end time
    set_regs(3, 40000, 0, 0);
    add_op(OP_WRITE, 2, -300);
    add_op(OP_STEP, 0, 0);
    add_op(OP_READ, 2, 0);
    wait_idle();

    // random phases, the receiver stalls long in the first
    for (int ph = 0; ph < 6; ph++) begin
      sp = (ph == 2) ? 40 : $urandom_range(2, 16);
      set_regs(sp, $urandom_range(65535), $urandom_range(1, 24'hFFFFFF),
               (ph % 2) ? $urandom_range(32'h0400_0000) : $urandom);
      if (ph == 0) hold_req = 1;
      if (ph == 5) quiet = 1;
      for (int i = 0; i < sp; i++) add_op(OP_WRITE, i, $signed($urandom_range(8000)) - 4000);
      random_ops(50, sp);
      wait_idle();
    end

    if (errors == 0)
      $display("PASS burgers_godunov_step_unit");
    else
      $display("FAIL burgers_godunov_step_unit");
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("FAIL burgers_godunov_step_unit");
    $finish;
  end
endmodule
